### sv/mbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types, constants and round functions of the Magma block cipher unit.
// ----------------------------------------------------------------------------
package mbc_pkg;

    localparam int ROUNDS     = 32;
    localparam int NUM_KEYS   = 8;
    localparam int WORD_W     = 32;
    localparam int BLOCK_W    = 64;
    localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
    localparam int ROUND_W    = $clog2(ROUNDS);
    localparam int ADDR_W     = KEY_IDX_W + 2;
    localparam int ROT        = 11;

    // operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] t_key_array;
    typedef logic [3:0] t_nibble;

    // sbox row j serves nibble j, counted from the least significant
    localparam t_nibble SBOX [0:7][0:15] = '{
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
    };

    // round function: key add, substitution, rotate left
    function automatic t_word mix(input t_word half, input t_word rkey);
        t_word sum;
        t_word sub;
        sum = half + rkey;
        for (int j = 0; j < 8; j++) begin
            sub[4*j +: 4] = SBOX[j][sum[4*j +: 4]];
        end
        return {sub[WORD_W-ROT-1:0], sub[WORD_W-1:WORD_W-ROT]};
    endfunction

    // key word used in a given round
    function automatic logic [KEY_IDX_W-1:0] key_index(input logic [ROUND_W-1:0] rnd,
                                                       input logic op);
        logic [KEY_IDX_W-1:0] fwd;
        logic [KEY_IDX_W-1:0] rev;
        fwd = rnd[KEY_IDX_W-1:0];
        rev = ~rnd[KEY_IDX_W-1:0];
        if (op == OP_ENCRYPT) begin
            return (rnd < ROUND_W'(ROUNDS - NUM_KEYS)) ? fwd : rev;
        end
        return (rnd < ROUND_W'(NUM_KEYS)) ? fwd : rev;
    endfunction

endpackage

### sv/mbc_key_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_key_regs
// Key word register file behind the configuration bus.
// ----------------------------------------------------------------------------
module mbc_key_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbc_pkg::WORD_W-1:0]  pwdata,
    output logic [mbc_pkg::WORD_W-1:0]  prdata,
    output logic                        pready,
    output mbc_pkg::t_key_array         o_keys
);
    import mbc_pkg::*;

    t_key_array              r_keys;
    logic [KEY_IDX_W-1:0]    w_idx;
    logic                    w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // key word write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (w_wr) begin
            r_keys[w_idx] <= pwdata;
        end
    end

    // readback
    assign prdata = r_keys[w_idx];
    assign o_keys = r_keys;

endmodule

### sv/mbc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_round
// One registered Feistel round: key add, sboxes, rotate, xor and swap.
// ----------------------------------------------------------------------------
module mbc_round (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_op,
    input  logic [mbc_pkg::WORD_W-1:0]  i_left,
    input  logic [mbc_pkg::WORD_W-1:0]  i_right,
    input  logic [mbc_pkg::WORD_W-1:0]  i_rkey,
    output logic                        o_valid,
    output logic                        o_op,
    output logic [mbc_pkg::WORD_W-1:0]  o_left,
    output logic [mbc_pkg::WORD_W-1:0]  o_right
);
    import mbc_pkg::*;

    logic    r_valid;
    logic    r_op;
    t_word   r_left;
    t_word   r_right;
    t_word   n_right;

    // new right half
    assign n_right = i_left ^ mix(i_right, i_rkey);

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_op    <= i_op;
        r_left  <= i_right;
        r_right <= n_right;
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

### sv/magma_block_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_block_cipher_unit
// Magma 64-bit block cipher, fully unrolled: one Feistel round per stage.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------
//   command   | i_start, o_busy      | i_opcode, i_block_in
//   result    | o_valid (strobe)     | o_block_out
//   config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A block enters on every cycle; its result strobes at the end of the pipeline.
// Latency is set by the 32 round stages, each holding one round of logic.
// o_busy stays low: the pipeline never stalls since results cannot be held.
// Reset clears the stage valid bits and the key words to zero.
// ----------------------------------------------------------------------------
module magma_block_cipher_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_opcode,
    input  logic [mbc_pkg::BLOCK_W-1:0] i_block_in,
    output logic                        o_valid,
    output logic [mbc_pkg::BLOCK_W-1:0] o_block_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbc_pkg::WORD_W-1:0]  pwdata,
    output logic [mbc_pkg::WORD_W-1:0]  prdata,
    output logic                        pready
);
    import mbc_pkg::*;

    t_key_array   w_keys;
    logic         w_valid [0:ROUNDS];
    logic         w_op    [0:ROUNDS];
    t_word        w_left  [0:ROUNDS];
    t_word        w_right [0:ROUNDS];
    t_word        w_rkey  [0:ROUNDS-1];

    // key registers
    mbc_key_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keys  (w_keys)
    );

    // pipeline entry
    assign o_busy     = 1'b0;
    assign w_valid[0] = i_start;
    assign w_op[0]    = i_opcode;
    assign w_left[0]  = i_block_in[BLOCK_W-1:WORD_W];
    assign w_right[0] = i_block_in[WORD_W-1:0];

    // round stages
    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        assign w_rkey[g] = w_keys[key_index(ROUND_W'(g), w_op[g])];

        mbc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_op    (w_op[g]),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_rkey  (w_rkey[g]),
            .o_valid (w_valid[g+1]),
            .o_op    (w_op[g+1]),
            .o_left  (w_left[g+1]),
            .o_right (w_right[g+1])
        );
    end

    // last round has no swap: undo it on the way out
    assign o_valid     = w_valid[ROUNDS];
    assign o_block_out = {w_right[ROUNDS], w_left[ROUNDS]};

    // every accepted command yields one result after the pipeline depth
    a_start_to_result : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##32 o_valid
    ) else $error("accepted transaction produced no result");

    // no result without a matching command
    a_no_spurious : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_start |-> ##32 !o_valid
    ) else $error("result strobe without a transaction");

    // a bus write lands in the addressed key word
    a_key_write : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=>
            (w_keys[$past(paddr[ADDR_W-1:2])] == $past(pwdata))
    ) else $error("key word write lost");

endmodule

### tb/magma_block_cipher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_block_cipher_unit_test
// Self-checking bench for the Magma block cipher unit. Keys are loaded over
// the APB port while the unit is idle; blocks are fed in random bursts and
// each strobed result is checked against an in-bench cipher computation.
// ----------------------------------------------------------------------------
module magma_block_cipher_unit_test;

    import mbc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 10;

    // substitution rows, nibble n of row j at bits [4n +: 4]
    localparam logic [7:0][63:0] SUBST_ROWS = {
        64'h2BC9_6AF4_3850_DE71,
        64'h73AD_0B4F_C196_52E8,
        64'h0E34_187B_AC29_6FD5,
        64'hC24B_E390_D618_A5F7,
        64'hB9E3_5A07_6F4D_128C,
        64'h069C_471E_DAF2_853B,
        64'hF0DB_74E1_C5A9_3286,
        64'h1F30_7D8E_9B5A_264C
    };

    typedef struct packed {
        logic              op;
        logic [BLOCK_W-1:0] blk;
    } t_cipher_cmd;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    logic                 i_opcode    = OP_ENCRYPT;
    logic [BLOCK_W-1:0]   i_block_in  = '0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [WORD_W-1:0]    pwdata      = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic [BLOCK_W-1:0]   o_block_out;
    logic [WORD_W-1:0]    prdata;
    logic                 pready;

    t_cipher_cmd          pending_cmds[$];
    logic [BLOCK_W-1:0]   expected_blocks[$];
    logic [WORD_W-1:0]    key_copy [NUM_KEYS];
    logic [BLOCK_W-1:0]   want_block;
    int                   error_count = 0;
    int                   burst_left  = 0;
    int                   gap_left    = 0;

    magma_block_cipher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_opcode    (i_opcode),
        .i_block_in  (i_block_in),
        .o_valid     (o_valid),
        .o_block_out (o_block_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // round function: key add, nibble substitution, rotate left by 11
    function automatic logic [WORD_W-1:0] feistel_f(input logic [WORD_W-1:0] half,
                                                    input logic [WORD_W-1:0] rkey);
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] sub;
        sum = half + rkey;
        for (int j = 0; j < 8; j++) begin
            sub[4*j +: 4] = SUBST_ROWS[j][4*sum[4*j +: 4] +: 4];
        end
        return {sub[20:0], sub[31:21]};
    endfunction

    // key schedule: encrypt K0..7 x3 then K7..0, decrypt K0..7 then K7..0 x3
    function automatic logic [WORD_W-1:0] round_key_word(input int rnd, input logic op);
        int idx;
        if (op == OP_ENCRYPT) begin
            idx = (rnd < 24) ? (rnd % 8) : (7 - rnd % 8);
        end else begin
            idx = (rnd < 8) ? rnd : (7 - rnd % 8);
        end
        return key_copy[idx];
    endfunction

    // full 32-round transform of one block under the current key copy
    function automatic logic [BLOCK_W-1:0] magma_transform(input logic op,
                                                           input logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] lh;
        logic [WORD_W-1:0] rh;
        logic [WORD_W-1:0] nr;
        lh = blk[63:32];
        rh = blk[31:0];
        for (int r = 0; r < ROUNDS - 1; r++) begin
            nr = lh ^ feistel_f(rh, round_key_word(r, op));
            lh = rh;
            rh = nr;
        end
        lh = lh ^ feistel_f(rh, round_key_word(ROUNDS - 1, op));
        return {lh, rh};
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_block();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return {32'hffff_ffff, $urandom};
            3:       return {$urandom, 32'h0000_0000};
            4:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_error(input string what, input logic [BLOCK_W-1:0] want,
                                input logic [BLOCK_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch (%s) at %0t: expected %h, got %h", what, $realtime, want, got);
        end
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(negedge i_clk) begin
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
            gap_left--;
            i_start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            burst_left--;
            i_start    <= 1'b1;
            i_opcode   <= pending_cmds[0].op;
            i_block_in <= pending_cmds[0].blk;
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor: record accepted transactions, check strobed results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && o_busy === 1'b0) begin
                expected_blocks.push_back(magma_transform(i_opcode, i_block_in));
                void'(pending_cmds.pop_front());
            end
            if (o_valid === 1'b1) begin
                if (expected_blocks.size() == 0) begin
                    report_error("unexpected result", '0, o_block_out);
                end else begin
                    want_block = expected_blocks.pop_front();
                    if (o_block_out !== want_block) begin
                        report_error("block_out", want_block, o_block_out);
                    end
                end
            end
        end
    end

    // one APB write: setup cycle, then access cycle until pready
    task automatic write_key(input int idx, input logic [WORD_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        key_copy[idx] = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_keys(input logic [NUM_KEYS-1:0][WORD_W-1:0] words);
        for (int i = 0; i < NUM_KEYS; i++) begin
            write_key(i, words[i]);
        end
    endtask

    // wait until every transaction has come back, then let the pipe settle
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || expected_blocks.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        t_cipher_cmd cmd;
        for (int n = 0; n < count; n++) begin
            cmd.op  = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
            cmd.blk = pick_block();
            pending_cmds.push_back(cmd);
        end
    endtask

    // timeout
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus sequence
    initial begin
        logic [9:0][BLOCK_W-1:0]          corner;
        logic [NUM_KEYS-1:0][WORD_W-1:0]  keys;
        t_cipher_cmd                      cmd;
        int                               tries;

        for (int i = 0; i < NUM_KEYS; i++) key_copy[i] = '0;
        corner = {64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
                  64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
                  64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff,
                  64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                  64'hfedc_ba98_7654_3210, 64'h4ee9_01e5_c2d8_ca3d};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key: corner blocks, decrypt first with no encrypt before it
        for (int i = 0; i < 10; i++) begin
            cmd.op  = OP_DECRYPT;
            cmd.blk = corner[i];
            pending_cmds.push_back(cmd);
            cmd.op  = OP_ENCRYPT;
            pending_cmds.push_back(cmd);
        end
        wait_idle();

        // all-ones key
        keys = '1;
        load_keys(keys);
        queue_random(50);
        wait_idle();

        // standard test key and its known plaintext / ciphertext pair
        keys = {32'hfcfdfeff, 32'hf8f9fafb, 32'hf4f5f6f7, 32'hf0f1f2f3,
                32'h33221100, 32'h77665544, 32'hbbaa9988, 32'hffeeddcc};
        load_keys(keys);
        cmd.op  = OP_ENCRYPT;
        cmd.blk = 64'hfedc_ba98_7654_3210;
        pending_cmds.push_back(cmd);
        cmd.op  = OP_DECRYPT;
        cmd.blk = 64'h4ee9_01e5_c2d8_ca3d;
        pending_cmds.push_back(cmd);
        queue_random(100);
        wait_idle();

        // random key phases, two of them with structured keys
        for (int p = 0; p < 6; p++) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (p == 0) begin
                    keys[i] = (i % 2) ? 32'hffff_ffff : 32'h0000_0000;
                end else if (p == 1) begin
                    keys[i] = 32'h1 << $urandom_range(0, 31);
                end else begin
                    keys[i] = $urandom;
                end
            end
            load_keys(keys);
            queue_random(130);
            wait_idle();
        end

        // back to an all-zero key after random ones
        keys = '0;
        load_keys(keys);
        queue_random(20);

        // final drain with a bound
        tries = 0;
        while ((pending_cmds.size() > 0 || expected_blocks.size() > 0) && tries < 5000) begin
            @(posedge i_clk);
            tries++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0 && pending_cmds.size() == 0 && expected_blocks.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### magma_block_cipher_unit.f
sv/mbc_pkg.sv
sv/mbc_key_regs.sv
sv/mbc_round.sv
sv/magma_block_cipher_unit.sv
tb/magma_block_cipher_unit_test.sv
